// ===== rtl/sdsc_pkg.sv =====
// Shared types and constants for the SD SPI-mode command engine.
// Transfer payload structs, op codes, register indexes and sequencer phases.
// No dependencies.
package sdsc_pkg;

    // op codes of an input transfer
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_RX    = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // configuration register indexes
    localparam logic REG_READY_TIMEOUT = 1'b0;
    localparam logic REG_RESP_ATTEMPTS = 1'b1;

    localparam logic [15:0] READY_TIMEOUT_RESET = 16'd500;
    localparam logic [7:0]  RESP_ATTEMPTS_RESET = 8'd10;

    localparam logic [7:0] BYTE_IDLE   = 8'hFF;
    localparam logic [7:0] START_BITS  = 8'h40;
    localparam logic [7:0] CRC_CMD0    = 8'h95;
    localparam logic [7:0] CRC_CMD8    = 8'h87;
    localparam logic [7:0] CRC_OTHER   = 8'h01;
    localparam logic [5:0] IDX_CMD0    = 6'd0;
    localparam logic [5:0] IDX_CMD8    = 6'd8;
    localparam logic [5:0] IDX_CMD12   = 6'd12;
    localparam logic [5:0] IDX_CMD55   = 6'd55;
    localparam logic [2:0] FRAME_LAST  = 3'd5;
    localparam logic [15:0] TICKS_MAX  = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DUMMY,
        PH_DISCARD,
        PH_READY,
        PH_FRAME,
        PH_STUFF,
        PH_RESP
    } t_phase;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  cmd_index;
        logic        app_cmd;
        logic [31:0] argument;
        logic [7:0]  rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       exchange;
        logic       card_select;
        logic [7:0] tx_byte;
        logic       done_res;
        logic [7:0] response;
        logic       busy_timeout;
    } t_out_item;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  byte_count;
        logic [15:0] elapsed_ticks;
        logic [7:0]  poll_left;
        logic [5:0]  saved_index;
        logic        app_pending;
        logic [31:0] saved_argument;
    } t_seq_state;

    typedef struct packed {
        logic [15:0] ready_timeout_ticks;
        logic [7:0]  response_attempts;
    } t_cfg;

endpackage

// ===== rtl/sdsc_stream_if.sv =====
// Valid/ready stream interface with a typed payload.
// Used for both the item and result channels; no package dependency.
interface sdsc_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sd_spi_command_engine.sv =====
// SD SPI-mode command engine: takes one item per cycle while the result
// channel keeps up. Each item (start, received byte or timer tick) is captured
// in an input register, passes through one sequencer step and lands in a result
// register once that register is free or being taken, and the result is offered
// from there. Ready drops only while an item is held in the input register and
// the result register is full and not being taken. Ticks and ignored items give
// no result transfer.
// Depends on sdsc_pkg, sdsc_stream_if and sdsc_step.
module sd_spi_command_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sdsc_stream_if.sink       i_in,
    sdsc_stream_if.source     o_out,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [15:0]       i_cfg_data
);
    import sdsc_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;
    t_seq_state r_state;
    t_seq_state n_state;
    t_cfg       r_cfg;
    logic       n_res_valid;
    t_out_item  n_res;
    logic       out_free;
    logic       advance;

    assign out_free    = !r_out_valid || o_out.ready;
    assign advance     = r_in_valid && out_free;
    assign i_in.ready  = !r_in_valid || advance;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    sdsc_step u_step (
        .i_state     (r_state),
        .i_item      (r_in_item),
        .i_cfg       (r_cfg),
        .o_state     (n_state),
        .o_res_valid (n_res_valid),
        .o_res       (n_res)
    );

    // capture an item on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_item <= i_in.data;
        end
    end

    // commit sequencer state and load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{phase: PH_IDLE, byte_count: 3'd0, elapsed_ticks: 16'd0,
                             poll_left: 8'd0, saved_index: 6'd0, app_pending: 1'b0,
                             saved_argument: 32'd0};
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= n_res_valid;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance && n_res_valid) begin
            r_out_item <= n_res;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ready_timeout_ticks <= READY_TIMEOUT_RESET;
            r_cfg.response_attempts   <= RESP_ATTEMPTS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_READY_TIMEOUT: r_cfg.ready_timeout_ticks <= i_cfg_data;
                REG_RESP_ATTEMPTS: r_cfg.response_attempts   <= i_cfg_data[7:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

endmodule

// ===== rtl/sdsc_step.sv =====
// One sequencer step: next state and optional result for one item.
// Depends on sdsc_pkg.
module sdsc_step (
    input  sdsc_pkg::t_seq_state i_state,
    input  sdsc_pkg::t_in_item   i_item,
    input  sdsc_pkg::t_cfg       i_cfg,
    output sdsc_pkg::t_seq_state o_state,
    output logic                 o_res_valid,
    output sdsc_pkg::t_out_item  o_res
);
    import sdsc_pkg::*;

    logic [5:0]  cur_idx;
    logic [31:0] cur_arg;
    logic [2:0]  next_count;
    logic [7:0]  next_poll;
    logic [7:0]  frame_tx;

    // pick the command bytes for the CMD55 prefix or the main command
    assign cur_idx    = i_state.app_pending ? IDX_CMD55 : i_state.saved_index;
    assign cur_arg    = i_state.app_pending ? 32'd0 : i_state.saved_argument;
    assign next_count = i_state.byte_count + 3'd1;
    assign next_poll  = i_state.poll_left - 8'd1;

    // frame byte for the next position
    always_comb begin
        case (next_count)
            3'd1: frame_tx = cur_arg[31:24];
            3'd2: frame_tx = cur_arg[23:16];
            3'd3: frame_tx = cur_arg[15:8];
            3'd4: frame_tx = cur_arg[7:0];
            default: begin
                if (cur_idx == IDX_CMD0) begin
                    frame_tx = CRC_CMD0;
                end else if (cur_idx == IDX_CMD8) begin
                    frame_tx = CRC_CMD8;
                end else begin
                    frame_tx = CRC_OTHER;
                end
            end
        endcase
    end

    always_comb begin
        logic       fin;
        logic [7:0] fin_res;
        logic       fin_busy;
        fin      = 1'b0;
        fin_res  = 8'd0;
        fin_busy = 1'b0;
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '0;

        case (i_item.op)
            OP_START: begin
                if (i_state.phase == PH_IDLE) begin
                    o_state.saved_index    = i_item.cmd_index;
                    o_state.app_pending    = i_item.app_cmd;
                    o_state.saved_argument = i_item.argument;
                    o_state.phase          = PH_DUMMY;
                    o_res_valid            = 1'b1;
                    o_res.exchange         = 1'b1;
                    o_res.tx_byte          = BYTE_IDLE;
                end
            end
            OP_RX: begin
                // default reply for every exchange: selected, send 0xFF
                o_res.exchange    = 1'b1;
                o_res.card_select = 1'b1;
                o_res.tx_byte     = BYTE_IDLE;
                o_res_valid       = (i_state.phase != PH_IDLE);
                case (i_state.phase)
                    PH_DUMMY: begin
                        o_state.phase         = PH_DISCARD;
                        o_state.elapsed_ticks = 16'd0;
                    end
                    PH_DISCARD: begin
                        o_state.phase = PH_READY;
                    end
                    PH_READY: begin
                        if (i_item.rx_byte == BYTE_IDLE) begin
                            o_state.phase      = PH_FRAME;
                            o_state.byte_count = 3'd0;
                            o_res.tx_byte      = START_BITS | {2'b00, cur_idx};
                        end else if (i_state.elapsed_ticks >= i_cfg.ready_timeout_ticks) begin
                            fin      = 1'b1;
                            fin_res  = BYTE_IDLE;
                            fin_busy = 1'b1;
                        end
                    end
                    PH_FRAME: begin
                        o_state.byte_count = next_count;
                        if (next_count <= FRAME_LAST) begin
                            o_res.tx_byte = frame_tx;
                        end else if (cur_idx == IDX_CMD12) begin
                            o_state.phase = PH_STUFF;
                        end else begin
                            o_state.phase     = PH_RESP;
                            o_state.poll_left = i_cfg.response_attempts;
                        end
                    end
                    PH_STUFF: begin
                        o_state.phase     = PH_RESP;
                        o_state.poll_left = i_cfg.response_attempts;
                    end
                    PH_RESP: begin
                        o_state.poll_left = next_poll;
                        if (!i_item.rx_byte[7] || next_poll == 8'd0) begin
                            fin     = 1'b1;
                            fin_res = i_item.rx_byte;
                        end
                    end
                    default: begin
                        o_state.phase = PH_IDLE;
                    end
                endcase

                // finish: chain into the main command after a good CMD55, else report the completion
                if (fin) begin
                    o_state.app_pending = 1'b0;
                    if (i_state.app_pending && !fin_busy && fin_res <= 8'd1) begin
                        o_state.phase     = PH_DUMMY;
                        o_res.card_select = 1'b0;
                    end else begin
                        o_state.phase      = PH_IDLE;
                        o_res.exchange     = 1'b0;
                        o_res.card_select  = 1'b0;
                        o_res.tx_byte      = 8'd0;
                        o_res.done_res     = 1'b1;
                        o_res.response     = fin_res;
                        o_res.busy_timeout = fin_busy;
                    end
                end
            end
            OP_TICK: begin
                if ((i_state.phase == PH_DISCARD || i_state.phase == PH_READY) &&
                    i_state.elapsed_ticks != TICKS_MAX) begin
                    o_state.elapsed_ticks = i_state.elapsed_ticks + 16'd1;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

// ===== rtl/sdsc_checker.sv =====
// Port-level checks for the SD SPI command engine, bound to the top level.
// Depends on the top level's result channel ports.
module sdsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic       i_exchange,
    input logic       i_card_select,
    input logic [7:0] i_tx_byte,
    input logic       i_done_res,
    input logic [7:0] i_response,
    input logic       i_busy_timeout
);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    // a stalled result transfer stays offered
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result dropped while stalled");

    // a completion carries no exchange request
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_done_res |-> !i_exchange && !i_card_select && i_tx_byte == 8'd0)
        else $error("completion mixed with exchange");

    // a busy timeout always reports 0xFF as a completion
    a_timeout_ff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_busy_timeout |-> i_done_res && i_response == 8'hFF)
        else $error("busy timeout with bad response");

endmodule

bind sd_spi_command_engine sdsc_checker u_sdsc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_out.valid),
    .i_ready        (o_out.ready),
    .i_exchange     (o_out.data.exchange),
    .i_card_select  (o_out.data.card_select),
    .i_tx_byte      (o_out.data.tx_byte),
    .i_done_res     (o_out.data.done_res),
    .i_response     (o_out.data.response),
    .i_busy_timeout (o_out.data.busy_timeout)
);
